@@ rtl/rsha_pkg.sv @@
// rsha_pkg: word width, rotation amounts, round constants and round functions
// for the reduced-width sha tail evaluator; no dependencies
`timescale 1ns / 1ps
package rsha_pkg;

  localparam int WORD_BITS = 16;
  localparam int FIELD_BITS = 16;
  localparam int WEIGHT_BITS = 8;
  localparam int WT_BITS = $clog2(8 * WORD_BITS + 1);
  localparam int CFG_ADDR_BITS = 2;
  localparam logic [CFG_ADDR_BITS-1:0] REG_MSG_WORD_ZERO = '0;

  typedef logic [WORD_BITS-1:0] word_t;
  typedef word_t state_t [8];
  typedef logic [WT_BITS-1:0] wt_t;

  // round-half-even of k*WORD_BITS/32, at least 1
  function automatic int scaled(input int k);
    int num, q, r;
    begin
      num = k * WORD_BITS;
      q = num / 32;
      r = num % 32;
      if (r > 16 || (r == 16 && (q % 2) == 1)) q = q + 1;
      return (q < 1) ? 1 : q;
    end
  endfunction

  localparam int R_B0A = scaled(2) % WORD_BITS;
  localparam int R_B0B = scaled(13) % WORD_BITS;
  localparam int R_B0C = scaled(22) % WORD_BITS;
  localparam int R_B1A = scaled(6) % WORD_BITS;
  localparam int R_B1B = scaled(11) % WORD_BITS;
  localparam int R_B1C = scaled(25) % WORD_BITS;
  localparam int R_S0A = scaled(7) % WORD_BITS;
  localparam int R_S0B = scaled(18) % WORD_BITS;
  localparam int S_S0 = scaled(3);
  localparam int R_S1A = scaled(17) % WORD_BITS;
  localparam int R_S1B = scaled(19) % WORD_BITS;
  localparam int S_S1 = scaled(10);

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,32'h923f82a4,
    32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,32'h72be5d74,32'h80deb1fe,
    32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,
    32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,
    32'hc6e00bf3,32'hd5a79147,32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,
    32'h53380d13,32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
    32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,32'h19a4c116,
    32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,32'h5b9cca4f,32'h682e6ff3,
    32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,32'h90befffa,32'ha4506ceb,32'hbef9a3f7,
    32'hc67178f2};

  localparam logic [31:0] START_IV [8] = '{
    32'h6a09e667,32'hbb67ae85,32'h3c6ef372,32'ha54ff53a,
    32'h510e527f,32'h9b05688c,32'h1f83d9ab,32'h5be0cd19};

  function automatic word_t kw(input int r);
    return ROUND_K[r][WORD_BITS-1:0];
  endfunction

  function automatic word_t rotr(input word_t x, input int k);
    return (k == 0) ? x : word_t'((x >> k) | (x << (WORD_BITS - k)));
  endfunction

  function automatic word_t shr(input word_t x, input int k);
    return (k >= WORD_BITS) ? '0 : word_t'(x >> k);
  endfunction

  function automatic word_t big0(input word_t x);
    return rotr(x, R_B0A) ^ rotr(x, R_B0B) ^ rotr(x, R_B0C);
  endfunction
  function automatic word_t big1(input word_t x);
    return rotr(x, R_B1A) ^ rotr(x, R_B1B) ^ rotr(x, R_B1C);
  endfunction
  function automatic word_t sml0(input word_t x);
    return rotr(x, R_S0A) ^ rotr(x, R_S0B) ^ shr(x, S_S0);
  endfunction
  function automatic word_t sml1(input word_t x);
    return rotr(x, R_S1A) ^ rotr(x, R_S1B) ^ shr(x, S_S1);
  endfunction

  function automatic word_t part_e(input state_t s, input int r);
    return word_t'(s[7] + big1(s[4]) + ((s[4] & s[5]) ^ (~s[4] & s[6])) + kw(r));
  endfunction
  function automatic word_t part_a(input state_t s);
    return word_t'(big0(s[0]) + ((s[0] & s[1]) ^ (s[0] & s[2]) ^ (s[1] & s[2])));
  endfunction

  function automatic state_t do_round(input state_t s, input int r, input word_t w);
    state_t n;
    word_t t1;
    begin
      t1 = word_t'(part_e(s, r) + w);
      n[7] = s[6]; n[6] = s[5]; n[5] = s[4];
      n[4] = word_t'(s[3] + t1);
      n[3] = s[2]; n[2] = s[1]; n[1] = s[0];
      n[0] = word_t'(t1 + part_a(s));
      return n;
    end
  endfunction

  function automatic word_t zero_a_word(input state_t p, input state_t q, input int r,
                                        input word_t w);
    return word_t'(w + part_e(p, r) - part_e(q, r) + part_a(p) - part_a(q));
  endfunction

  function automatic word_t zero_e_word(input state_t p, input state_t q, input int r,
                                        input word_t w);
    return word_t'(w + p[3] - q[3] + part_e(p, r) - part_e(q, r));
  endfunction

  function automatic wt_t diff_weight(input state_t p, input state_t q);
    wt_t n;
    begin
      n = '0;
      for (int i = 0; i < 8; i++) n = wt_t'(n + wt_t'($countones(p[i] ^ q[i])));
      return n;
    end
  endfunction

  // one context per message: start state and schedule words 44..48, 53..56
  typedef struct packed {
    logic [7:0][WORD_BITS-1:0] st;
    logic [8:0][WORD_BITS-1:0] sch;
  } ctx_t;

endpackage

@@ rtl/rsha_if.sv @@
// rsha_if: valid/ready channel carrying a payload of type t
// depends on nothing
`timescale 1ns / 1ps
interface rsha_if #(parameter type T = logic) (input logic clk);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ rtl/rsha_derive.sv @@
// rsha_derive: sequential derivation of one message's round-57 context
// one schedule word and one round per cycle; depends on rsha_pkg
`timescale 1ns / 1ps
module rsha_derive (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  rsha_pkg::word_t        word_zero,
  input  logic                   flip,
  output logic                   done,
  output rsha_pkg::ctx_t         ctx
);
  import rsha_pkg::*;

  // 16-word sliding schedule window; w_r[0] is word i
  word_t  w_r [16];
  word_t  w_nxt [16];
  state_t s_r, s_nxt;
  logic [5:0] i_r, i_nxt;
  logic busy_r, busy_nxt;
  logic done_r, done_nxt;
  logic [8:0][WORD_BITS-1:0] sch_r, sch_nxt;
  word_t msb;
  word_t new_w;

  assign msb = word_t'(1) << (WORD_BITS - 1);

  always_comb begin
    w_nxt = w_r;
    s_nxt = s_r;
    i_nxt = i_r;
    busy_nxt = busy_r;
    done_nxt = done_r;
    sch_nxt = sch_r;
    new_w = word_t'(sml1(w_r[14]) + w_r[9] + sml0(w_r[1]) + w_r[0]);
    if (start) begin
      for (int j = 0; j < 16; j++) w_nxt[j] = '1;
      w_nxt[0] = word_zero ^ (flip ? msb : '0);
      w_nxt[9] = ~(flip ? msb : '0);
      for (int j = 0; j < 8; j++) s_nxt[j] = START_IV[j][WORD_BITS-1:0];
      i_nxt = '0;
      busy_nxt = 1'b1;
      done_nxt = 1'b0;
    end else if (busy_r) begin
      s_nxt = do_round(s_r, int'(i_r), w_r[0]);
      for (int j = 0; j < 15; j++) w_nxt[j] = w_r[j+1];
      w_nxt[15] = new_w;
      if (i_r >= 6'd44 && i_r <= 6'd48) sch_nxt[4'(i_r - 6'd44)] = w_r[0];
      if (i_r >= 6'd53) sch_nxt[4'(i_r - 6'd48)] = w_r[0];
      i_nxt = 6'(i_r + 6'd1);
      if (i_r == 6'd56) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      i_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      i_r <= i_nxt;
    end
    w_r <= w_nxt;
    s_r <= s_nxt;
    sch_r <= sch_nxt;
  end

  assign done = done_r;
  always_comb begin
    for (int j = 0; j < 8; j++) ctx.st[j] = s_r[j];
    ctx.sch = sch_r;
  end
endmodule

@@ rtl/rsha_pipe.sv @@
// rsha_pipe: evaluation pipeline, one round pair per stage, stall-safe
// depends on rsha_pkg
`timescale 1ns / 1ps
module rsha_pipe (
  input  logic                  clk,
  input  logic                  rst_n,
  input  rsha_pkg::ctx_t        ctx_a,
  input  rsha_pkg::ctx_t        ctx_b,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  rsha_pkg::word_t       w57,
  input  rsha_pkg::word_t       w58,
  input  rsha_pkg::word_t       w59,
  output logic                  out_valid,
  input  logic                  out_ready,
  output rsha_pkg::word_t       v57_o,
  output rsha_pkg::word_t       v58_o,
  output rsha_pkg::word_t       v59_o,
  output rsha_pkg::word_t       d60_o,
  output logic                  ran_o,
  output rsha_pkg::wt_t         wt61_o,
  output rsha_pkg::wt_t         wt63_o
);
  import rsha_pkg::*;

  localparam int NS = 7;

  typedef struct packed {
    logic [7:0][WORD_BITS-1:0] p;
    logic [7:0][WORD_BITS-1:0] q;
    logic [WORD_BITS-1:0] w58, w59, v57, v58, v59, x60, y60, x61, y61, x62, y62, d60;
    logic [WT_BITS-1:0] wt61;
  } stg_t;

  logic v_r [NS];
  stg_t d_r [NS];
  stg_t d_nxt [NS];
  logic adv [NS];
  state_t p, q, pn, qn;

  function automatic state_t unpk(input logic [7:0][WORD_BITS-1:0] x);
    state_t s;
    for (int j = 0; j < 8; j++) s[j] = x[j];
    return s;
  endfunction
  function automatic logic [7:0][WORD_BITS-1:0] pk(input state_t s);
    logic [7:0][WORD_BITS-1:0] x;
    for (int j = 0; j < 8; j++) x[j] = s[j];
    return x;
  endfunction
  function automatic word_t sa(input ctx_t c, input int n);
    return (n <= 48) ? c.sch[n-44] : c.sch[n-53+5];
  endfunction
  function automatic word_t sched(input ctx_t c, input word_t w2, input int n);
    return word_t'(sml1(w2) + sa(c, n-7) + sml0(sa(c, n-15)) + sa(c, n-16));
  endfunction

  // stall logic: a stage advances when it is empty or the next one advances
  always_comb begin
    adv[NS-1] = !v_r[NS-1] || out_ready;
    for (int k = NS-2; k >= 0; k--) adv[k] = !v_r[k] || adv[k+1];
  end
  assign in_ready = adv[0];

  always_comb begin
    stg_t s;
    state_t tp, tq;
    word_t v;
    // stage 0: round 57
    s = '0;
    tp = unpk(ctx_a.st);
    tq = unpk(ctx_b.st);
    v = zero_a_word(tp, tq, 57, w57);
    s.v57 = v;
    s.w58 = w58;
    s.w59 = w59;
    s.p = pk(do_round(tp, 57, w57));
    s.q = pk(do_round(tq, 57, v));
    d_nxt[0] = s;
    // stage 1: round 58, schedule word 60
    s = d_r[0];
    tp = unpk(s.p);
    tq = unpk(s.q);
    v = zero_a_word(tp, tq, 58, s.w58);
    s.v58 = v;
    s.x60 = sched(ctx_a, s.w58, 60);
    s.y60 = sched(ctx_b, v, 60);
    s.p = pk(do_round(tp, 58, s.w58));
    s.q = pk(do_round(tq, 58, v));
    d_nxt[1] = s;
    // stage 2: round 59, schedule words 61/62
    s = d_r[1];
    tp = unpk(s.p);
    tq = unpk(s.q);
    v = zero_a_word(tp, tq, 59, s.w59);
    s.v59 = v;
    s.x61 = sched(ctx_a, s.w59, 61);
    s.y61 = sched(ctx_b, v, 61);
    s.x62 = sched(ctx_a, s.x60, 62);
    s.y62 = sched(ctx_b, s.y60, 62);
    s.p = pk(do_round(tp, 59, s.w59));
    s.q = pk(do_round(tq, 59, v));
    d_nxt[2] = s;
    // stage 3: interface difference, round 60
    s = d_r[2];
    tp = unpk(s.p);
    tq = unpk(s.q);
    s.d60 = word_t'(s.y60 - zero_e_word(tp, tq, 60, s.x60));
    s.p = pk(do_round(tp, 60, s.x60));
    s.q = pk(do_round(tq, 60, s.y60));
    d_nxt[3] = s;
    // stage 4: round 61
    s = d_r[3];
    s.p = pk(do_round(unpk(s.p), 61, s.x61));
    s.q = pk(do_round(unpk(s.q), 61, s.y61));
    d_nxt[4] = s;
    // stage 5: weight 61, round 62; w58 and w59 slots reused for word 63
    s = d_r[4];
    s.wt61 = diff_weight(unpk(s.p), unpk(s.q));
    s.w58 = sched(ctx_a, s.x61, 63);
    s.w59 = sched(ctx_b, s.y61, 63);
    s.p = pk(do_round(unpk(s.p), 62, s.x62));
    s.q = pk(do_round(unpk(s.q), 62, s.y62));
    d_nxt[5] = s;
    // stage 6: round 63
    s = d_r[5];
    s.p = pk(do_round(unpk(s.p), 63, s.w58));
    s.q = pk(do_round(unpk(s.q), 63, s.w59));
    d_nxt[6] = s;
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NS; k++) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (adv[k]) begin
        v_r[k] <= (k == 0) ? in_valid : v_r[k-1 < 0 ? 0 : k-1];
      end
      if (adv[k]) d_r[k] <= d_nxt[k];
    end
  end

  assign p = unpk(d_r[NS-1].p);
  assign q = unpk(d_r[NS-1].q);
  assign pn = p;
  assign qn = q;
  assign out_valid = v_r[NS-1];
  assign v57_o = d_r[NS-1].v57;
  assign v58_o = d_r[NS-1].v58;
  assign v59_o = d_r[NS-1].v59;
  assign d60_o = d_r[NS-1].d60;
  assign ran_o = (d_r[NS-1].d60 == '0);
  assign wt61_o = ran_o ? d_r[NS-1].wt61 : '0;
  assign wt63_o = ran_o ? diff_weight(pn, qn) : '0;
endmodule

@@ rtl/reduced_sha_tail_difference_eval_core.sv @@
// reduced_sha_tail_difference_eval_core: top level with apb register and channels
// depends on rsha_pkg, rsha_if, rsha_derive, rsha_pipe
`timescale 1ns / 1ps
// Evaluates the sha-256 tail (rounds 57..63) at a reduced word width for a pair
// of messages derived from the configured message word zero. After reset or a
// write of message_word_zero the two round-57 contexts are rebuilt by two
// sequencers running side by side, one round per cycle; no request is taken
// meanwhile. Then one request (first-message words 57..59) is accepted every
// cycle while the result side does not stall, through a seven-stage pipeline,
// one round pair per stage, and each result is read from the last stage's
// register. Stalls on the result side back up through the stages without loss.
module reduced_sha_tail_difference_eval_core (
  input  logic        clk,
  input  logic        rst_n,
  rsha_if.sink        in_ch,
  rsha_if.source      out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [rsha_pkg::CFG_ADDR_BITS-1:0] cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import rsha_pkg::*;

  logic [FIELD_BITS-1:0] mwz_r;
  logic ctx_ready_r, ctx_ready_nxt;
  logic start_r;
  logic wr;
  logic done_a, done_b;
  ctx_t ctx_a, ctx_b;
  logic pipe_in_ready;
  word_t v57, v58, v59, d60;
  logic ran;
  wt_t wt61, wt63;

  // register write; index other than zero ignored
  assign wr = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == REG_MSG_WORD_ZERO) ? 32'(mwz_r) : '0;

  // context rebuild kicks off in the cycle after reset or a write
  always_comb begin
    ctx_ready_nxt = ctx_ready_r;
    if (done_a && done_b && !start_r) ctx_ready_nxt = 1'b1;
    if (wr && cfg_paddr == REG_MSG_WORD_ZERO) ctx_ready_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mwz_r <= '0;
      ctx_ready_r <= 1'b0;
      start_r <= 1'b1;
    end else begin
      if (wr && cfg_paddr == REG_MSG_WORD_ZERO) mwz_r <= cfg_pwdata[FIELD_BITS-1:0];
      start_r <= wr && cfg_paddr == REG_MSG_WORD_ZERO;
      ctx_ready_r <= ctx_ready_nxt;
    end
  end

  rsha_derive u_der_a (
    .clk(clk), .rst_n(rst_n), .start(start_r), .word_zero(word_t'(mwz_r)),
    .flip(1'b0), .done(done_a), .ctx(ctx_a)
  );
  rsha_derive u_der_b (
    .clk(clk), .rst_n(rst_n), .start(start_r), .word_zero(word_t'(mwz_r)),
    .flip(1'b1), .done(done_b), .ctx(ctx_b)
  );

  assign in_ch.ready = pipe_in_ready && ctx_ready_r;

  rsha_pipe u_pipe (
    .clk(clk), .rst_n(rst_n), .ctx_a(ctx_a), .ctx_b(ctx_b),
    .in_valid(in_ch.valid && ctx_ready_r), .in_ready(pipe_in_ready),
    .w57(word_t'(in_ch.data.first_free_word)),
    .w58(word_t'(in_ch.data.second_free_word)),
    .w59(word_t'(in_ch.data.third_free_word)),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .v57_o(v57), .v58_o(v58), .v59_o(v59), .d60_o(d60), .ran_o(ran),
    .wt61_o(wt61), .wt63_o(wt63)
  );

  assign out_ch.data.partner_word_57 = FIELD_BITS'(v57);
  assign out_ch.data.partner_word_58 = FIELD_BITS'(v58);
  assign out_ch.data.partner_word_59 = FIELD_BITS'(v59);
  assign out_ch.data.interface_difference = FIELD_BITS'(d60);
  assign out_ch.data.tail_evaluated = ran;
  assign out_ch.data.round61_weight = WEIGHT_BITS'(wt61);
  assign out_ch.data.final_weight = WEIGHT_BITS'(wt63);
endmodule
